// ===== rtl/oapm_pkg.sv =====
// shared types, constants, rounding and saturation helpers for the off-axis projection core
`timescale 1ns / 1ps
package oapm_pkg;

	localparam int COORD_W = 21;
	localparam int VEC_W   = 3 * COORD_W;
	localparam int CLIP_W  = 32;

	localparam logic [2:0] CFG_BL   = 3'd0;
	localparam logic [2:0] CFG_BR   = 3'd1;
	localparam logic [2:0] CFG_TL   = 3'd2;
	localparam logic [2:0] CFG_WD   = 3'd3;
	localparam logic [2:0] CFG_HD   = 3'd4;
	localparam logic [2:0] CFG_ND   = 3'd5;
	localparam logic [2:0] CFG_NEAR = 3'd6;
	localparam logic [2:0] CFG_FAR  = 3'd7;

	localparam logic [VEC_W-1:0]  WD_RST   = 63'd16384;
	localparam logic [VEC_W-1:0]  HD_RST   = 63'd34359738368;
	localparam logic [VEC_W-1:0]  ND_RST   = 63'd72057594037927936;
	localparam logic [CLIP_W-1:0] NEAR_RST = 32'd6554;
	localparam logic [CLIP_W-1:0] FAR_RST  = 32'd65536000;

	localparam logic [1:0] ROW_LAST = 2'd3;

	localparam int DIV_QB  = 34;
	localparam int DIV_LAT = DIV_QB + 2;

	localparam logic signed [31:0] S32_MAX = 32'sh7fffffff;
	localparam logic signed [31:0] S32_MIN = 32'sh80000000;

	typedef logic signed [COORD_W-1:0] coord_t;

	typedef struct packed {
		logic              flt;
		logic signed [31:0] val;
	} sat_t;

	// round to nearest, ties away from zero
	function automatic logic signed [63:0] rshr(input logic signed [63:0] v, input int sh);
		logic [63:0] m;
		m = v[63] ? 64'(-v) : 64'(v);
		m = (m + (64'd1 << (sh - 1))) >> sh;
		return v[63] ? -$signed(m) : $signed(m);
	endfunction

	function automatic sat_t sat32(input logic signed [63:0] v);
		sat_t r;
		if (v > 64'(S32_MAX)) begin
			r.flt = 1'b1;
			r.val = S32_MAX;
		end else if (v < 64'(S32_MIN)) begin
			r.flt = 1'b1;
			r.val = S32_MIN;
		end else begin
			r.flt = 1'b0;
			r.val = 32'(v);
		end
		return r;
	endfunction

endpackage

// ===== rtl/off_axis_projection_matrix_core.sv =====
// top level: off-axis projection matrix pipeline with row serializer
//
// channel   dir  handshake             payload
// s_axis    in   tvalid/tready         tdata: eye_x, eye_y, eye_z
// m_axis    out  tvalid/tready         tdata: row_index, col0..col3; tlast; tuser
// cfg       in   cfg_valid/cfg_ready   cfg_index, cfg_data
//
// an item offers its four rows one a cycle while m_axis_tready is high
// the six dividers take one quotient bit per stage and set the middle stages
// the row serializer sets throughput: a new item loads as its last row leaves
// reset clears all valid bits and loads the default display configuration
// with v_s7 set a stall freezes all stages at once; none is lost or repeated
`timescale 1ns / 1ps
module off_axis_projection_matrix_core #(
	parameter int COORD_FRAC_BITS = 14,
	parameter int OUT_FRAC_BITS   = 16
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_axis_tvalid,
	output logic         s_axis_tready,
	input  logic [63:0]  s_axis_tdata,   // eye_x, eye_y, eye_z, pad
	output logic         m_axis_tvalid,
	input  logic         m_axis_tready,
	output logic [135:0] m_axis_tdata,   // row_index, col0, col1, col2, col3, pad
	output logic         m_axis_tlast,
	output logic         m_axis_tuser,   // divider fault, zero eye distance or near, or saturation fault
	input  logic         cfg_valid,
	output logic         cfg_ready,
	input  logic [2:0]   cfg_index,
	input  logic [63:0]  cfg_data
);

	localparam int VW = oapm_pkg::VEC_W;
	localparam int CL = oapm_pkg::CLIP_W;
	localparam int P23_NSH = (OUT_FRAC_BITS >= 15) ? OUT_FRAC_BITS - 14 : 0;
	localparam int P23_DSH = (OUT_FRAC_BITS < 15) ? 14 - OUT_FRAC_BITS : 0;

	// configuration
	logic [VW-1:0] bl_q, br_q, tl_q, wd_q, hd_q, nd_q;
	logic [CL-1:0] near_q, far_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bl_q   <= '0;
			br_q   <= '0;
			tl_q   <= '0;
			wd_q   <= oapm_pkg::WD_RST;
			hd_q   <= oapm_pkg::HD_RST;
			nd_q   <= oapm_pkg::ND_RST;
			near_q <= oapm_pkg::NEAR_RST;
			far_q  <= oapm_pkg::FAR_RST;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				oapm_pkg::CFG_BL:   bl_q   <= cfg_data[VW-1:0];
				oapm_pkg::CFG_BR:   br_q   <= cfg_data[VW-1:0];
				oapm_pkg::CFG_TL:   tl_q   <= cfg_data[VW-1:0];
				oapm_pkg::CFG_WD:   wd_q   <= cfg_data[VW-1:0];
				oapm_pkg::CFG_HD:   hd_q   <= cfg_data[VW-1:0];
				oapm_pkg::CFG_ND:   nd_q   <= cfg_data[VW-1:0];
				oapm_pkg::CFG_NEAR: near_q <= cfg_data[CL-1:0];
				oapm_pkg::CFG_FAR:  far_q  <= cfg_data[CL-1:0];
				default: ;
			endcase
		end
	end

	oapm_pkg::coord_t bl_c [3], br_c [3], tl_c [3], w_c [3], h_c [3], n_c [3], e_c [3];

	always_comb begin
		for (int j = 0; j < 3; j++) begin
			bl_c[j] = bl_q[j*21 +: 21];
			br_c[j] = br_q[j*21 +: 21];
			tl_c[j] = tl_q[j*21 +: 21];
			w_c[j]  = wd_q[j*21 +: 21];
			h_c[j]  = hd_q[j*21 +: 21];
			n_c[j]  = nd_q[j*21 +: 21];
			e_c[j]  = s_axis_tdata[j*21 +: 21];
		end
	end

	// pipeline control
	logic en, ser_free, load;
	logic v_s1, v_s2, v_s3, v_d, v_s4, v_s5, v_s6, v_s7;
	logic out_valid_q;
	logic [1:0] row_q;

	assign ser_free      = !out_valid_q || (m_axis_tready && row_q == oapm_pkg::ROW_LAST);
	assign en            = !v_s7 || ser_free;
	assign load          = en && v_s7;
	assign s_axis_tready = en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
			v_s7 <= 1'b0;
		end else if (en) begin
			v_s1 <= s_axis_tvalid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_d;
			v_s5 <= v_s4;
			v_s6 <= v_s5;
			v_s7 <= v_s6;
		end
	end

	// corner offsets, dot products
	logic [VW-1:0]       e_s1, e_s2, e_s3;
	logic signed [21:0]  vbl_s1 [3], vbr_s1 [3], vtl_s1 [3];
	logic signed [42:0]  pn_s2 [3], pwl_s2 [3], pwr_s2 [3], pwb_s2 [3], pwt_s2 [3];
	logic [63:0]         prod_s2, prod_s3;
	logic signed [44:0]  dist_s3;
	logic signed [43:0]  wl_s3, wr_s3, wb_s3, wt_s3;

	always_ff @(posedge clk) begin
		if (en) begin
			e_s1 <= s_axis_tdata[VW-1:0];
			for (int j = 0; j < 3; j++) begin
				vbl_s1[j] <= 22'(bl_c[j]) - 22'(e_c[j]);
				vbr_s1[j] <= 22'(br_c[j]) - 22'(e_c[j]);
				vtl_s1[j] <= 22'(tl_c[j]) - 22'(e_c[j]);
			end
			e_s2    <= e_s1;
			prod_s2 <= 64'(far_q) * 64'(near_q);
			for (int j = 0; j < 3; j++) begin
				pn_s2[j]  <= 43'(n_c[j]) * 43'(vbl_s1[j]);
				pwl_s2[j] <= 43'(w_c[j]) * 43'(vbl_s1[j]);
				pwr_s2[j] <= 43'(w_c[j]) * 43'(vbr_s1[j]);
				pwb_s2[j] <= 43'(h_c[j]) * 43'(vbl_s1[j]);
				pwt_s2[j] <= 43'(h_c[j]) * 43'(vtl_s1[j]);
			end
			e_s3    <= e_s2;
			prod_s3 <= prod_s2;
			dist_s3 <= -(45'(pn_s2[0]) + 45'(pn_s2[1]) + 45'(pn_s2[2]));
			wl_s3   <= 44'(pwl_s2[0]) + 44'(pwl_s2[1]) + 44'(pwl_s2[2]);
			wr_s3   <= 44'(pwr_s2[0]) + 44'(pwr_s2[1]) + 44'(pwr_s2[2]);
			wb_s3   <= 44'(pwb_s2[0]) + 44'(pwb_s2[1]) + 44'(pwb_s2[2]);
			wt_s3   <= 44'(pwt_s2[0]) + 44'(pwt_s2[1]) + 44'(pwt_s2[2]);
		end
	end

	// divider operands
	function automatic logic [45:0] mag46(input logic signed [45:0] x);
		return x[45] ? 46'(-x) : 46'(x);
	endfunction

	logic signed [45:0] nx, dx, na, ny, dy, nb;
	logic               neg_x, neg_a, neg_y, neg_b, neg_c, neg_d, flt0;
	logic [32:0]        fsum;
	logic [31:0]        fdif;

	always_comb begin
		nx    = 46'(dist_s3) <<< 1;
		dx    = 46'(wr_s3) - 46'(wl_s3);
		na    = 46'(wr_s3) + 46'(wl_s3);
		ny    = nx;
		dy    = 46'(wt_s3) - 46'(wb_s3);
		nb    = 46'(wt_s3) + 46'(wb_s3);
		neg_x = (nx[45] != dx[45]) && nx != '0;
		neg_a = (na[45] != dx[45]) && na != '0;
		neg_y = (ny[45] != dy[45]) && ny != '0;
		neg_b = (nb[45] != dy[45]) && nb != '0;
		fsum  = 33'(far_q) + 33'(near_q);
		fdif  = (far_q >= near_q) ? far_q - near_q : near_q - far_q;
		neg_c = fsum != '0 && far_q >= near_q;
		neg_d = far_q > near_q && prod_s3 != '0;
		flt0  = dist_s3 == '0 || near_q == '0;
	end

	logic signed [31:0] q00, q02, q11, q12, q22, q23;
	logic               f00, f02, f11, f12, f22, f23;

	oapm_div #(.NW(46), .DW(46), .NSH(OUT_FRAC_BITS + 1), .DSH(0)) u_div_x (
		.clk(clk), .en(en), .num(mag46(nx)), .den(mag46(dx)), .neg(neg_x), .quo(q00), .flt(f00)
	);
	oapm_div #(.NW(46), .DW(46), .NSH(OUT_FRAC_BITS + 1), .DSH(0)) u_div_a (
		.clk(clk), .en(en), .num(mag46(na)), .den(mag46(dx)), .neg(neg_a), .quo(q02), .flt(f02)
	);
	oapm_div #(.NW(46), .DW(46), .NSH(OUT_FRAC_BITS + 1), .DSH(0)) u_div_y (
		.clk(clk), .en(en), .num(mag46(ny)), .den(mag46(dy)), .neg(neg_y), .quo(q11), .flt(f11)
	);
	oapm_div #(.NW(46), .DW(46), .NSH(OUT_FRAC_BITS + 1), .DSH(0)) u_div_b (
		.clk(clk), .en(en), .num(mag46(nb)), .den(mag46(dy)), .neg(neg_b), .quo(q12), .flt(f12)
	);
	oapm_div #(.NW(33), .DW(32), .NSH(OUT_FRAC_BITS + 1), .DSH(0)) u_div_c (
		.clk(clk), .en(en), .num(fsum), .den(fdif), .neg(neg_c), .quo(q22), .flt(f22)
	);
	oapm_div #(.NW(64), .DW(32), .NSH(P23_NSH), .DSH(P23_DSH)) u_div_d (
		.clk(clk), .en(en), .num(prod_s3), .den(fdif), .neg(neg_d), .quo(q23), .flt(f23)
	);

	logic [VW:0] side_d;

	oapm_dly #(.W(VW + 1), .D(oapm_pkg::DIV_LAT)) u_side (
		.clk(clk), .arst_n(arst_n), .en(en), .din_valid(v_s3), .din({flt0, e_s3}),
		.dout_valid(v_d), .dout(side_d)
	);

	// matrix product after the dividers
	logic [VW-1:0]       e_s4, e_s5;
	logic signed [52:0]  pa_s4 [3], pb_s4 [3], pc_s4 [3], pd_s4 [3], pe_s4 [3];
	logic signed [31:0]  p23_s4, p23_s5, p23_s6;
	logic                flt_s4, flt_s5, flt_s6, flt_s7;
	logic signed [31:0]  mat_s5 [4][3], mat_s6 [4][3], mat_s7 [4][4];
	logic signed [52:0]  qe_s6 [4][3];

	oapm_pkg::sat_t sm [4][3];
	oapm_pkg::sat_t sc [4];
	logic           flt_m, flt_c;

	always_comb begin
		flt_m = 1'b0;
		for (int j = 0; j < 3; j++) begin
			sm[0][j] = oapm_pkg::sat32(oapm_pkg::rshr(64'(pa_s4[j]) + 64'(pb_s4[j]),
				COORD_FRAC_BITS));
			sm[1][j] = oapm_pkg::sat32(oapm_pkg::rshr(64'(pc_s4[j]) + 64'(pd_s4[j]),
				COORD_FRAC_BITS));
			sm[2][j] = oapm_pkg::sat32(oapm_pkg::rshr(64'(pe_s4[j]), COORD_FRAC_BITS));
			sm[3][j] = oapm_pkg::sat32(oapm_pkg::rshr(-(64'(n_c[j]) <<< OUT_FRAC_BITS),
				COORD_FRAC_BITS));
		end
		for (int i = 0; i < 4; i++)
			for (int j = 0; j < 3; j++) flt_m = flt_m | sm[i][j].flt;
		flt_c = 1'b0;
		for (int i = 0; i < 4; i++) begin
			sc[i] = oapm_pkg::sat32(((i == 2) ? 64'(p23_s6) : 64'sd0) -
				oapm_pkg::rshr(64'(qe_s6[i][0]) + 64'(qe_s6[i][1]) + 64'(qe_s6[i][2]),
				COORD_FRAC_BITS));
			flt_c = flt_c | sc[i].flt;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			e_s4   <= side_d[VW-1:0];
			flt_s4 <= side_d[VW] | f00 | f02 | f11 | f12 | f22 | f23;
			p23_s4 <= q23;
			for (int j = 0; j < 3; j++) begin
				pa_s4[j] <= 53'(q00) * 53'(w_c[j]);
				pb_s4[j] <= 53'(q02) * 53'(n_c[j]);
				pc_s4[j] <= 53'(q11) * 53'(h_c[j]);
				pd_s4[j] <= 53'(q12) * 53'(n_c[j]);
				pe_s4[j] <= 53'(q22) * 53'(n_c[j]);
			end
			e_s5   <= e_s4;
			p23_s5 <= p23_s4;
			flt_s5 <= flt_s4 | flt_m;
			for (int i = 0; i < 4; i++)
				for (int j = 0; j < 3; j++) mat_s5[i][j] <= sm[i][j].val;
			p23_s6 <= p23_s5;
			flt_s6 <= flt_s5;
			for (int i = 0; i < 4; i++)
				for (int j = 0; j < 3; j++) begin
					mat_s6[i][j] <= mat_s5[i][j];
					qe_s6[i][j]  <= 53'(mat_s5[i][j]) * 53'($signed(e_s5[j*21 +: 21]));
				end
			flt_s7 <= flt_s6 | flt_c;
			for (int i = 0; i < 4; i++) begin
				for (int j = 0; j < 3; j++) mat_s7[i][j] <= mat_s6[i][j];
				mat_s7[i][3] <= sc[i].val;
			end
		end
	end

	// row serializer
	logic signed [31:0] out_mat_q [4][4];
	logic               out_flt_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			row_q       <= '0;
		end else if (load) begin
			out_valid_q <= 1'b1;
			row_q       <= '0;
		end else if (out_valid_q && m_axis_tready) begin
			if (row_q == oapm_pkg::ROW_LAST) out_valid_q <= 1'b0;
			row_q <= row_q + 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			out_mat_q <= mat_s7;
			out_flt_q <= flt_s7;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {6'd0, out_mat_q[row_q][3], out_mat_q[row_q][2],
		out_mat_q[row_q][1], out_mat_q[row_q][0], row_q};
	assign m_axis_tlast  = row_q == oapm_pkg::ROW_LAST;
	assign m_axis_tuser  = out_flt_q;

	a_row_step: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && m_axis_tready && row_q != oapm_pkg::ROW_LAST) |=>
		(m_axis_tvalid && row_q == $past(row_q) + 2'd1))
		else $error("row did not advance");

	a_hold_front: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s7 && !ser_free) |-> !s_axis_tready)
		else $error("pipeline advanced into busy serializer");

	a_drain: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && m_axis_tready && m_axis_tlast && !v_s7) |=> !m_axis_tvalid)
		else $error("result shown after last row");

	a_load_row0: assert property (@(posedge clk) disable iff (!arst_n)
		load |=> (m_axis_tvalid && row_q == '0))
		else $error("new matrix not started at row 0");

endmodule

// ===== rtl/oapm_div.sv =====
// pipelined restoring divider, one quotient bit per stage, rounded and saturated result
`timescale 1ns / 1ps
module oapm_div #(
	parameter int NW  = 46,
	parameter int DW  = 46,
	parameter int NSH = 17,
	parameter int DSH = 0
) (
	input  logic               clk,
	input  logic               en,
	input  logic [NW-1:0]      num,
	input  logic [DW-1:0]      den,
	input  logic               neg,
	output logic signed [31:0] quo,
	output logic               flt
);

	localparam int RW  = NW + NSH;
	localparam int DDW = DW + DSH;
	localparam int QB  = oapm_pkg::DIV_QB;
	localparam int CW  = (RW > DDW + QB) ? RW : DDW + QB;

	logic [CW-1:0]  rem_sk [QB+1];
	logic [DDW-1:0] den_sk [QB+1];
	logic [QB-1:0]  quo_sk [QB+1];
	logic           neg_sk [QB+1];
	logic           dz_sk  [QB+1];
	logic           nz_sk  [QB+1];

	always_ff @(posedge clk) begin
		if (en) begin
			rem_sk[0] <= CW'(num) << NSH;
			den_sk[0] <= DDW'(den) << DSH;
			quo_sk[0] <= '0;
			neg_sk[0] <= neg;
			dz_sk[0]  <= (den == '0);
			nz_sk[0]  <= (num == '0);
		end
	end

	for (genvar g = 0; g < QB; g++) begin : g_bit
		logic [CW-1:0] dsh;
		logic          ge;
		assign dsh = CW'(den_sk[g]) << (QB - 1 - g);
		assign ge  = rem_sk[g] >= dsh;
		always_ff @(posedge clk) begin
			if (en) begin
				rem_sk[g+1] <= ge ? rem_sk[g] - dsh : rem_sk[g];
				den_sk[g+1] <= den_sk[g];
				quo_sk[g+1] <= {quo_sk[g][QB-2:0], ge};
				neg_sk[g+1] <= neg_sk[g];
				dz_sk[g+1]  <= dz_sk[g];
				nz_sk[g+1]  <= nz_sk[g];
			end
		end
	end

	logic        big;
	logic [QB-1:0] mag;

	assign big = quo_sk[QB][QB-1];
	assign mag = ({1'b0, quo_sk[QB][QB-2:0]} + QB'(1)) >> 1;

	always_ff @(posedge clk) begin
		if (en) begin
			if (dz_sk[QB]) begin
				flt <= !nz_sk[QB];
				quo <= nz_sk[QB] ? '0 : (neg_sk[QB] ? oapm_pkg::S32_MIN : oapm_pkg::S32_MAX);
			end else if (neg_sk[QB]) begin
				if (big || mag > QB'(33'h080000000)) begin
					flt <= 1'b1;
					quo <= oapm_pkg::S32_MIN;
				end else begin
					flt <= 1'b0;
					quo <= 32'(-mag);
				end
			end else begin
				if (big || mag > QB'(33'h07fffffff)) begin
					flt <= 1'b1;
					quo <= oapm_pkg::S32_MAX;
				end else begin
					flt <= 1'b0;
					quo <= 32'(mag);
				end
			end
		end
	end

endmodule

// ===== rtl/oapm_dly.sv =====
// stallable delay line that carries a valid bit with its data
`timescale 1ns / 1ps
module oapm_dly #(
	parameter int W = 64,
	parameter int D = 36
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         en,
	input  logic         din_valid,
	input  logic [W-1:0] din,
	output logic         dout_valid,
	output logic [W-1:0] dout
);

	logic         vld_sk [D];
	logic [W-1:0] dat_sk [D];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < D; i++) vld_sk[i] <= 1'b0;
		end else if (en) begin
			vld_sk[0] <= din_valid;
			for (int i = 1; i < D; i++) vld_sk[i] <= vld_sk[i-1];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			dat_sk[0] <= din;
			for (int i = 1; i < D; i++) dat_sk[i] <= dat_sk[i-1];
		end
	end

	assign dout_valid = vld_sk[D-1];
	assign dout       = dat_sk[D-1];

endmodule
